@@ sv/evti_pkg.sv @@
package evti_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSTALLED = 3'd0,
        ST_END       = 3'd1,
        ST_ERROR     = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_LOOKUP    = 3'd4
    } status_t;

    // Operation codes
    localparam logic OP_INSTALL = 1'b0;
    localparam logic OP_LOOKUP  = 1'b1;

    localparam logic [15:0] END_CODE  = 16'hFFFF;
    localparam int unsigned SLOTS     = 10;
    localparam logic [13:0] FIRST_VEC = 14'd2;
    localparam logic [13:0] LAST_VEC  = 14'd11;
    localparam logic [31:0] PAIR_SIZE = 32'd4;

    typedef struct packed {
        logic              operation;
        logic              table_start;
        logic [3:0]        process;
        logic [31:0]       pair_address;
        logic [15:0]       code_word;
        logic signed [15:0] rel_offset;
        logic [31:0]       exception_stack;
        logic [7:0]        vector;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  installed_count;
        logic [31:0] handler_address;
    } result_t;

endpackage

@@ sv/evti_store.sv @@
module evti_store #(
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_handler,
    input  logic [31:0]       wr_stack,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data,
    output logic              clearing
);
    import evti_pkg::*;

    logic [31:0]       handler_mem [DEPTH];
    logic [31:0]       stack_mem   [DEPTH];
    logic [31:0]       rd_data_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [ADDR_W-1:0] clr_idx_next;
    logic              clr_last;

    assign clr_last = (clr_idx_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_last)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Sweep zeros through both stores after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            handler_mem[clr_idx_reg] <= '0;
            stack_mem[clr_idx_reg]   <= '0;
        end
        else if (wr_en)
        begin
            handler_mem[wr_addr] <= wr_handler;
            stack_mem[wr_addr]   <= wr_stack;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= handler_mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

    a_no_access_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!wr_en && !rd_en)
    ) else $error("store accessed during clearing pass");

    a_clear_ends_at_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (clearing_reg && clr_last) |=> !clearing_reg
    ) else $error("clearing pass did not end at last entry");

endmodule

@@ sv/evti_ctrl.sv @@
module evti_ctrl #(
    parameter int PROCESSES = 16,
    parameter int MAX_PAIRS = 40,
    parameter int ADDR_W    = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  evti_pkg::item_t   item,
    output logic              wr_en,
    output logic              rd_en,
    output logic [ADDR_W-1:0] slot,
    output evti_pkg::result_t res,
    output logic              use_mem
);
    import evti_pkg::*;

    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        closed_reg;
    logic        closed_next;
    logic        err_reg;
    logic        err_next;
    logic        proc_ok;
    logic [13:0] vec_num;
    logic        vec_ok;
    logic [3:0]  vec_idx;
    logic [31:0] handler;
    logic        install;
    logic        hit;

    assign proc_ok = (item.process != 4'd0) && (32'(item.process) < 32'(PROCESSES));
    assign vec_num = (item.operation == OP_LOOKUP) ? {6'd0, item.vector}
                                                   : item.code_word[15:2];
    assign vec_ok  = (vec_num >= FIRST_VEC) && (vec_num <= LAST_VEC);
    assign vec_idx = 4'(vec_num - FIRST_VEC);
    assign slot    = ADDR_W'(32'(item.process) * SLOTS + 32'(vec_idx));
    assign handler = item.pair_address + PAIR_SIZE
                   + {{16{item.rel_offset[15]}}, item.rel_offset};

    always_comb
    begin
        cnt_next    = cnt_reg;
        closed_next = closed_reg;
        err_next    = err_reg;
        install     = 1'b0;
        hit         = 1'b0;
        res.status          = ST_IGNORED;
        res.handler_address = '0;
        if (item.operation == OP_LOOKUP)
        begin
            res.status = ST_LOOKUP;
            hit        = proc_ok && vec_ok;
        end
        else
        begin
            // Open a fresh table before judging the pair
            if (item.table_start)
            begin
                cnt_next    = '0;
                closed_next = 1'b0;
                err_next    = 1'b0;
            end
            priority if (closed_next)
            begin
                res.status = err_next ? ST_ERROR : ST_IGNORED;
            end
            else if (cnt_next >= 6'(MAX_PAIRS))
            begin
                res.status = ST_IGNORED;
            end
            else if (!proc_ok || (item.table_start && item.pair_address == '0)
                     || (item.code_word != END_CODE
                         && (item.code_word[1:0] != 2'd0 || !vec_ok)))
            begin
                res.status  = ST_ERROR;
                closed_next = 1'b1;
                err_next    = 1'b1;
            end
            else if (item.code_word == END_CODE)
            begin
                res.status  = ST_END;
                closed_next = 1'b1;
            end
            else
            begin
                res.status          = ST_INSTALLED;
                res.handler_address = handler;
                cnt_next            = cnt_next + 6'd1;
                install             = 1'b1;
            end
        end
        res.installed_count = cnt_next;
    end

    assign wr_en   = fire && install;
    assign rd_en   = fire && hit;
    assign use_mem = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            closed_reg <= 1'b1;
            err_reg    <= 1'b0;
        end
        else if (fire)
        begin
            cnt_reg    <= cnt_next;
            closed_reg <= closed_next;
            err_reg    <= err_next;
        end
    end

endmodule

@@ sv/exception_vector_table_installer_unit.sv @@
// Exception vector table installer.
//
// Input channel item/item_valid/item_ready carries one beat per table word
// pair (install) or per handler query (lookup). Output channel
// result/result_valid/result_ready returns exactly one beat per input beat,
// in order.
//
// The result of a beat is valid in the cycle after it is accepted.
// One beat per cycle while result_ready is high. Each install is a single
// write to the handler and stack memories; each lookup is a single read
// whose data comes out of the memory's output register in the next cycle.
//
// Reset: a clearing pass zeroes all PROCESSES*10 entries of both memories,
// one entry per cycle; item_ready stays low until it finishes. The table
// is closed, the pair count and the error flag are zero.
//
// Stall: the result register holds its beat while result_ready is low; a
// new item is taken in the cycle that the held beat drains.
module exception_vector_table_installer_unit #(
    parameter int PROCESSES = 16,
    parameter int MAX_PAIRS = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  evti_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_ready,
    output evti_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);
    import evti_pkg::*;

    localparam int DEPTH  = PROCESSES * SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              fire;
    logic              clearing;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] slot;
    logic [31:0]       rd_data;
    result_t           ctrl_res;
    logic              use_mem;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           res_reg;
    logic              use_mem_reg;

    // Accept when the result slot is free or drains this cycle
    assign item_ready = !clearing && (!out_valid_reg || result_ready);
    assign fire       = item_valid && item_ready;

    evti_ctrl #(
        .PROCESSES (PROCESSES),
        .MAX_PAIRS (MAX_PAIRS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .slot    (slot),
        .res     (ctrl_res),
        .use_mem (use_mem)
    );

    evti_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (slot),
        .wr_handler (ctrl_res.handler_address),
        .wr_stack   (item.exception_stack),
        .rd_en      (rd_en),
        .rd_addr    (slot),
        .rd_data    (rd_data),
        .clearing   (clearing)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the beat payload; lookup data stays in the memory output register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg     <= ctrl_res;
            use_mem_reg <= use_mem;
        end
    end

    always_comb
    begin
        result = res_reg;
        if (use_mem_reg)
        begin
            result.handler_address = rd_data;
        end
    end

    assign result_valid = out_valid_reg;

    a_result_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg
    ) else $error("no result after accepted item");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.installed_count <= 6'(MAX_PAIRS))
    ) else $error("installed count beyond pair limit");

    a_error_zero_handler: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.status == ST_ERROR || res_reg.status == ST_END))
            |-> (result.handler_address == 32'd0 && !use_mem_reg)
    ) else $error("nonzero handler on error or table end");

endmodule

@@ tb/tb_exception_vector_table_installer_unit.sv @@
`timescale 1ns / 1ps

module tb_exception_vector_table_installer_unit;

    import evti_pkg::*;

    localparam int N_PROCESSES = 16;
    localparam int N_MAX_PAIRS = 40;
    localparam int HOLD_CYCLES = 80;     // long receiver hold-off
    localparam int N_RANDOM    = 1400;   // beats in the random part

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    item_t   item = '0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    result_t result;
    logic    result_valid;
    logic    result_ready = 1'b0;

    exception_vector_table_installer_unit #(
        .PROCESSES(N_PROCESSES),
        .MAX_PAIRS(N_MAX_PAIRS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

    // 4 ns period, two delays per cycle
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the installer state. It advances once per accepted
    // input beat, in acceptance order, so the queue below always holds
    // the answers the block still owes, oldest first.
    // ------------------------------------------------------------------
    logic [31:0] handler_tbl [0:N_PROCESSES*SLOTS-1];
    logic [31:0] stack_tbl   [0:N_PROCESSES*SLOTS-1];
    logic [5:0]  pair_count;
    logic        table_open;
    logic        err_latched;

    result_t     owed_results [$];

    // run control shared by the sender, the receiver and the tests
    bit          steady_mode  = 1'b0;   // no idling on either side
    bit          hold_request = 1'b0;   // ask the receiver for a long hold
    int          hold_left    = 0;

    int          beats_sent   = 0;
    int          beats_checked = 0;
    int          mismatches   = 0;
    int          status_seen [0:7];

    function automatic bit proc_ok(input logic [3:0] p);
        return p != 4'd0 && int'(p) < N_PROCESSES;
    endfunction

    // Work out the answer to one beat and advance the shadow state.
    function automatic result_t predict_beat(input item_t it);
        result_t     r;
        logic [13:0] vnum;
        int          slot;
        logic [31:0] rel_ext;
        r.status          = ST_LOOKUP;
        r.installed_count = pair_count;
        r.handler_address = '0;

        // lookup: read only, vectors outside the trappable range answer 0
        if (it.operation == OP_LOOKUP)
        begin
            if (proc_ok(it.process) && 14'(it.vector) >= FIRST_VEC
                && 14'(it.vector) <= LAST_VEC)
                r.handler_address =
                    handler_tbl[int'(it.process) * SLOTS + int'(it.vector) - int'(FIRST_VEC)];
            return r;
        end

        // a new table resets the count and clears any latched error first
        if (it.table_start)
        begin
            pair_count  = '0;
            table_open  = 1'b1;
            err_latched = 1'b0;
        end

        vnum = it.code_word[15:2];
        if (!table_open)
            r.status = err_latched ? ST_ERROR : ST_IGNORED;
        else if (int'(pair_count) >= N_MAX_PAIRS)
            r.status = ST_IGNORED;
        else if (!proc_ok(it.process) || (it.table_start && it.pair_address == '0))
        begin
            table_open  = 1'b0;
            err_latched = 1'b1;
            r.status    = ST_ERROR;
        end
        else if (it.code_word == END_CODE)
        begin
            table_open = 1'b0;
            r.status   = ST_END;
        end
        else if (it.code_word[1:0] != 2'b00 || vnum < FIRST_VEC || vnum > LAST_VEC)
        begin
            // bad entry: close the table, keep what is already written
            table_open  = 1'b0;
            err_latched = 1'b1;
            r.status    = ST_ERROR;
        end
        else
        begin
            slot = int'(it.process) * SLOTS + int'(vnum) - int'(FIRST_VEC);
            rel_ext = {{16{it.rel_offset[15]}}, it.rel_offset};
            handler_tbl[slot]  = it.pair_address + PAIR_SIZE + rel_ext;
            stack_tbl[slot]    = it.exception_stack;
            pair_count         = pair_count + 6'd1;
            r.status           = ST_INSTALLED;
            r.handler_address  = handler_tbl[slot];
        end
        r.installed_count = pair_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders: fields that the operation does not use stay random
    // so every input bit toggles over the run.
    // ------------------------------------------------------------------
    function automatic item_t random_beat();
        item_t it;
        it.operation       = 1'($urandom);
        it.table_start     = 1'($urandom);
        it.process         = 4'($urandom);
        it.pair_address    = $urandom;
        it.code_word       = 16'($urandom);
        it.rel_offset      = 16'($urandom);
        it.exception_stack = $urandom;
        it.vector          = 8'($urandom);
        return it;
    endfunction

    function automatic item_t install_beat(input logic start, input logic [3:0] p,
                                           input logic [31:0] addr, input logic [15:0] code,
                                           input logic [15:0] rel, input logic [31:0] stk);
        item_t it;
        it                 = random_beat();
        it.operation       = OP_INSTALL;
        it.table_start     = start;
        it.process         = p;
        it.pair_address    = addr;
        it.code_word       = code;
        it.rel_offset      = rel;
        it.exception_stack = stk;
        return it;
    endfunction

    function automatic item_t lookup_beat(input logic [3:0] p, input logic [7:0] vec);
        item_t it;
        it           = random_beat();
        it.operation = OP_LOOKUP;
        it.process   = p;
        it.vector    = vec;
        return it;
    endfunction

    // code word for a trappable vector 2..11
    function automatic logic [15:0] vector_code(input int vec);
        return 16'(vec * 4);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one beat, hold it until accepted, then record what
    // the block owes for it. Valid is left high on return; a caller that
    // stops sending calls release_input so the beat is not taken twice.
    // ------------------------------------------------------------------
    task automatic send_beat(input item_t it);
        while (!steady_mode && $urandom_range(99) < 32)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        owed_results.push_back(predict_beat(it));
        beats_sent++;
    endtask

    task automatic release_input();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and wait until every owed answer has come back
    task automatic drain_results();
        release_input();
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, a long hold-off on request, counted here.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                result_ready <= 1'b0;
            end
            else if (steady_mode)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(99) >= 32);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output beat against the oldest owed answer.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at beat %0d: %s expected %0h, got %0h",
                     beats_checked, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (owed_results.size() == 0)
                report_mismatch("unexpected beat, status", '0, 32'(result.status));
            else
            begin
                want = owed_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(result.status));
                if (result.installed_count !== want.installed_count)
                    report_mismatch("installed_count", 32'(want.installed_count),
                                    32'(result.installed_count));
                if (result.handler_address !== want.handler_address)
                    report_mismatch("handler_address", want.handler_address,
                                    result.handler_address);
                status_seen[want.status]++;
            end
            beats_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // all stores are clear after reset
    task automatic test_lookups_after_reset();
        send_beat(lookup_beat(4'd1, 8'd2));
        send_beat(lookup_beat(4'd15, 8'd11));
        send_beat(lookup_beat(4'd0, 8'd5));
        send_beat(lookup_beat(4'd8, 8'd255));
    endtask

    // field extremes, table end, errors and their latching
    task automatic test_directed_cases();
        // max positive and max negative distance, stack extremes
        send_beat(install_beat(1'b1, 4'd5, 32'h0000_1000, vector_code(2), 16'h7FFF, '0));
        send_beat(install_beat(1'b0, 4'd5, 32'h0000_1004, vector_code(11), 16'h8000, '1));
        // handler address wraps around 2^32
        send_beat(install_beat(1'b0, 4'd5, 32'hFFFF_FFFC, vector_code(3), 16'h0000, '0));
        send_beat(install_beat(1'b0, 4'd5, 32'hFFFF_FFFF, vector_code(4), 16'hFFFF, '1));
        send_beat(install_beat(1'b0, 4'd5, 32'h0000_1010, END_CODE, 16'h0, '0));
        // table closed without an error: ignored
        send_beat(install_beat(1'b0, 4'd5, 32'h0000_1014, vector_code(5), 16'h10, '0));
        send_beat(lookup_beat(4'd5, 8'd2));
        send_beat(lookup_beat(4'd5, 8'd11));
        send_beat(lookup_beat(4'd5, 8'd1));
        send_beat(lookup_beat(4'd5, 8'd12));
        send_beat(lookup_beat(4'd0, 8'd2));
        send_beat(lookup_beat(4'd15, 8'd255));
        // offset not a multiple of four, then the error stays latched
        send_beat(install_beat(1'b1, 4'd15, 32'hFFFF_FFFF, 16'h0006, 16'h0, '1));
        send_beat(install_beat(1'b0, 4'd15, 32'h0000_0100, vector_code(2), 16'h0, '0));
        // no process descriptor, null table
        send_beat(install_beat(1'b1, 4'd0, 32'h0000_0004, vector_code(2), 16'h0, '0));
        send_beat(install_beat(1'b1, 4'd3, 32'h0000_0000, vector_code(2), 16'h0, '0));
        // vectors just outside the trappable range, and the largest offset
        send_beat(install_beat(1'b1, 4'd3, 32'h0000_0200, vector_code(1), 16'h0, '0));
        send_beat(install_beat(1'b1, 4'd3, 32'h0000_0200, vector_code(12), 16'h0, '0));
        send_beat(install_beat(1'b1, 4'd3, 32'h0000_0200, 16'hFFFC, 16'h0, '0));
        // empty table
        send_beat(install_beat(1'b1, 4'd3, 32'h0000_0200, END_CODE, 16'h0, '0));
        // error in the middle of a table keeps the earlier slot
        send_beat(install_beat(1'b1, 4'd3, 32'h0000_0300, vector_code(10), 16'h0, '0));
        send_beat(install_beat(1'b0, 4'd0, 32'h0000_0304, vector_code(2), 16'h0, '0));
        send_beat(lookup_beat(4'd3, 8'd10));
        // address 0 is fine after the first pair
        send_beat(install_beat(1'b1, 4'd7, 32'h0000_0008, vector_code(6), 16'h20, '0));
        send_beat(install_beat(1'b0, 4'd7, 32'h0000_0000, vector_code(7), 16'hFFF0, '1));
    endtask

    // fill one table past its pair limit; the end code is ignored too
    task automatic test_pair_limit();
        logic [31:0] base;
        base = $urandom & 32'hFFFF_FFF0;
        base = base | 32'h10;
        for (int i = 0; i < N_MAX_PAIRS + 2; i++)
            send_beat(install_beat(i == 0, 4'd9, base + 32'(4 * i),
                                   vector_code($urandom_range(11, 2)),
                                   16'($urandom), $urandom));
        send_beat(install_beat(1'b0, 4'd9, base + 32'h200, END_CODE, 16'h0, '0));
        send_beat(lookup_beat(4'd9, 8'($urandom_range(11, 2))));
    endtask

    // receiver holds off while the sender keeps offering: input stalls
    task automatic test_backpressure();
        hold_request = 1'b1;
        steady_mode  = 1'b1;
        for (int i = 0; i < 30; i++)
            if (i % 3 == 0)
                send_beat(lookup_beat(4'($urandom_range(15, 1)), 8'($urandom_range(11, 2))));
            else
                send_beat(install_beat(i == 1, 4'd12, 32'h4000 + 32'(4 * i),
                                       vector_code($urandom_range(11, 2)),
                                       16'($urandom), $urandom));
        steady_mode = 1'b0;
    endtask

    // sender pauses until the block has answered everything
    task automatic test_drain_pause();
        drain_results();
        send_beat(lookup_beat(4'd12, 8'd2));
        send_beat(install_beat(1'b1, 4'd12, 32'h8000, END_CODE, 16'h0, '0));
    endtask

    // one table with random content, mostly well-formed, lookups mixed in
    task automatic send_random_table();
        logic [3:0]  p;
        logic [31:0] addr;
        int          pairs;
        p     = ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
        addr  = ($urandom_range(29) == 0) ? 32'd0 : $urandom;
        pairs = ($urandom_range(24) == 0) ? $urandom_range(45, 30) : $urandom_range(12, 1);
        for (int i = 0; i < pairs; i++)
        begin
            if ($urandom_range(3) == 0)
                send_beat(lookup_beat(4'($urandom),
                                      ($urandom_range(9) < 7) ? 8'($urandom_range(13))
                                                              : 8'($urandom)));
            // mostly good entries, now and then a noise offset
            send_beat(install_beat(i == 0, p, addr,
                                   ($urandom_range(19) == 0) ? 16'($urandom)
                                       : vector_code($urandom_range(11, 2)),
                                   16'($urandom), $urandom));
            addr = addr + PAIR_SIZE;
        end
        if ($urandom_range(4) != 0)
            send_beat(install_beat(1'b0, p, addr, END_CODE, 16'($urandom), $urandom));
        // stray pairs with random fields that start no table
        repeat ($urandom_range(2))
            send_beat(install_beat(1'b0, 4'($urandom), $urandom, 16'($urandom),
                                   16'($urandom), $urandom));
    endtask

    task automatic test_random_tables();
        int first;
        first = beats_sent;
        while (beats_sent - first < N_RANDOM)
        begin
            // a long stretch with no idling on either side
            steady_mode = (beats_sent - first >= 500 && beats_sent - first < 800);
            if ($urandom_range(9) == 0)
                send_beat(random_beat());
            else
                send_random_table();
        end
        steady_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < N_PROCESSES * SLOTS; i++)
        begin
            handler_tbl[i] = '0;
            stack_tbl[i]   = '0;
        end
        pair_count  = '0;
        table_open  = 1'b0;
        err_latched = 1'b0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;

        // hold reset, then release it; the clearing pass after it is covered
        // by waiting on item_ready
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_lookups_after_reset();
        test_directed_cases();
        test_pair_limit();
        test_backpressure();
        test_drain_pause();
        test_random_tables();

        drain_results();
        // let any stray beat show up before the verdict
        repeat (10) @(posedge clk);

        $display("Run sent %0d beats and checked %0d answers over directed, pair-limit,",
                 beats_sent, beats_checked);
        $display({"backpressure and random table cases: %0d installed, %0d ends, ",
                  "%0d errors, %0d ignored, %0d lookups"},
                 status_seen[ST_INSTALLED], status_seen[ST_END], status_seen[ST_ERROR],
                 status_seen[ST_IGNORED], status_seen[ST_LOOKUP]);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #800000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
